// ----- hdl/hct_pkg.sv -----
// ----------------------------------------------------------------------------
// Hermite curve tessellator package
// Widths, types and fixed limits shared by the tessellator modules.
// ----------------------------------------------------------------------------
package hct_pkg;

   localparam int COORD_W = 18;
   localparam int TAN_W   = 19;
   localparam int COEF_W  = 17;
   localparam int PROD_W  = TAN_W + COEF_W;
   localparam int ACC_W   = PROD_W + 2;
   localparam int SEG_W   = 5;
   localparam int SQ_W    = 2 * SEG_W;
   localparam int CUBE_W  = 3 * SEG_W;
   localparam int HSUM_W  = 19;
   localparam int QUO_W   = 19;
   localparam int MAG_W   = CUBE_W + QUO_W;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [TAN_W-1:0]   tan_type;
   typedef logic signed [COEF_W-1:0]  coef_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [ACC_W-1:0]   acc_type;
   typedef logic signed [HSUM_W-1:0]  hsum_type;
   typedef logic [SEG_W-1:0]          seg_type;
   typedef logic [SQ_W-1:0]           sq_type;
   typedef logic [CUBE_W-1:0]         cube_type;
   typedef logic [MAG_W-1:0]          mag_type;
   typedef logic [QUO_W-1:0]          quo_type;

   localparam seg_type   SEG_RESET     = 5'd8;
   localparam coord_type COORD_MAX     = 18'sh1FFFF;
   localparam coord_type COORD_MIN     = 18'sh20000;
   localparam quo_type   QUO_POS_LIMIT = 19'd131071;
   localparam quo_type   QUO_NEG_LIMIT = 19'd131072;

   typedef struct packed {
      logic issue;
      logic first;
   } mac_ctrl_type;

   typedef struct packed {
      logic      done;
      coord_type value;
   } div_result_type;

endpackage

// ----- hdl/hct_mac.sv -----
// ----------------------------------------------------------------------------
// Hermite curve tessellator multiply-accumulate unit
// Shared signed multiplier with a registered product and an accumulator.
// ----------------------------------------------------------------------------
module hct_mac (
   input  logic                  clock,
   input  logic                  reset,
   input  hct_pkg::mac_ctrl_type ctrl,
   input  hct_pkg::tan_type      op_a,
   input  hct_pkg::coef_type     op_b,
   output hct_pkg::prod_type     product,
   output hct_pkg::acc_type      acc
);

   logic              valid_ff;
   logic              first_ff;
   hct_pkg::prod_type prod_ff;
   hct_pkg::prod_type prod_in;
   hct_pkg::acc_type  acc_ff;
   hct_pkg::acc_type  acc_in;

   always_comb begin
      prod_in = op_a * op_b;
      acc_in  = (first_ff ? '0 : acc_ff) + hct_pkg::acc_type'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         first_ff <= 1'b0;
      end else begin
         valid_ff <= ctrl.issue;
         first_ff <= ctrl.first;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.issue) begin
         prod_ff <= prod_in;
      end
      if (valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign product = prod_ff;
   assign acc     = acc_ff;

endmodule

// ----- hdl/hct_div.sv -----
// ----------------------------------------------------------------------------
// Hermite curve tessellator divider
// Restoring divider, one quotient bit a cycle, rounding half away from zero
// and saturating to the coordinate range.
// ----------------------------------------------------------------------------
module hct_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  hct_pkg::acc_type        dividend,
   input  hct_pkg::cube_type       divisor,
   output hct_pkg::div_result_type result
);

   localparam int CNT_W    = $clog2(hct_pkg::QUO_W);
   localparam int FinDelay = hct_pkg::QUO_W + 1;
   localparam logic [CNT_W-1:0] CntLast = CNT_W'(hct_pkg::QUO_W - 1);

   logic               busy_ff;
   logic               fin_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               neg_ff;
   hct_pkg::cube_type  div_ff;
   hct_pkg::cube_type  rem_ff;
   hct_pkg::cube_type  rem_in;
   hct_pkg::quo_type   low_ff;
   hct_pkg::quo_type   low_in;
   hct_pkg::coord_type value_ff;
   hct_pkg::coord_type value_in;

   hct_pkg::acc_type        half_s;
   hct_pkg::acc_type        mag_s;
   hct_pkg::mag_type        mag;
   logic [hct_pkg::CUBE_W:0] trial;
   logic [hct_pkg::CUBE_W:0] diff;
   logic                     ge;
   hct_pkg::quo_type         neg_q;

   always_comb begin
      half_s = hct_pkg::acc_type'(divisor[hct_pkg::CUBE_W-1:1]);
      mag_s  = dividend[hct_pkg::ACC_W-1] ? (half_s - dividend) : (dividend + half_s);
      mag    = mag_s[hct_pkg::MAG_W-1:0];
      trial  = {rem_ff, low_ff[hct_pkg::QUO_W-1]};
      diff   = trial - {1'b0, div_ff};
      ge     = (trial >= {1'b0, div_ff});
      rem_in = ge ? diff[hct_pkg::CUBE_W-1:0] : trial[hct_pkg::CUBE_W-1:0];
      low_in = {low_ff[hct_pkg::QUO_W-2:0], ge};
      neg_q  = -low_ff;
      if (neg_ff) begin
         value_in = (low_ff > hct_pkg::QUO_NEG_LIMIT) ? hct_pkg::COORD_MIN :
                    neg_q[hct_pkg::COORD_W-1:0];
      end else begin
         value_in = (low_ff > hct_pkg::QUO_POS_LIMIT) ? hct_pkg::COORD_MAX :
                    low_ff[hct_pkg::COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= start || (busy_ff && (cnt_ff != CntLast));
         fin_ff  <= busy_ff && (cnt_ff == CntLast);
         done_ff <= fin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= '0;
         neg_ff <= dividend[hct_pkg::ACC_W-1];
         div_ff <= divisor;
         rem_ff <= mag[hct_pkg::MAG_W-1:hct_pkg::QUO_W];
         low_ff <= mag[hct_pkg::QUO_W-1:0];
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         rem_ff <= rem_in;
         low_ff <= low_in;
      end
      if (fin_ff) begin
         value_ff <= value_in;
      end
   end

   assign result.done  = done_ff;
   assign result.value = value_ff;

`ifndef ASSERT_OFF
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff && !fin_ff && !done_ff)
      else $error("divider started while still working");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##FinDelay fin_ff)
      else $error("divider finish not at expected cycle");
`endif

endmodule

// ----- hdl/hermite_curve_tessellator_top.sv -----
// ----------------------------------------------------------------------------
// Hermite curve tessellator
// Evaluates one 2D cubic Hermite segment at n+1 evenly spaced parameters.
//
//   channel  ports        direction  carries
//   req      req_*        in         end points and tangent handles
//   rsp      rsp_*        out        one curve point, its index, last flag
//   csr      csr_*        in         segment count, written when idle
//
// n is the clamped segment count; a point waits in the output state while
// rsp_stall holds a valid point. Each point first forms the basis weights,
// then per axis runs four multiply-accumulates and a division in the
// one-bit-a-cycle divider. One shared multiplier serves all products.
// req_stall is high from acceptance until the final point is registered.
// Synchronous reset sets the segment count to 8 and empties the output.
// ----------------------------------------------------------------------------
module hermite_curve_tessellator_top #(
   parameter int MAX_SEGMENTS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  hct_pkg::coord_type       req_start_x,
   input  hct_pkg::coord_type       req_start_y,
   input  hct_pkg::coord_type       req_end_x,
   input  hct_pkg::coord_type       req_end_y,
   input  hct_pkg::coord_type       req_start_handle_x,
   input  hct_pkg::coord_type       req_start_handle_y,
   input  hct_pkg::coord_type       req_end_handle_x,
   input  hct_pkg::coord_type       req_end_handle_y,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output hct_pkg::coord_type       rsp_point_x,
   output hct_pkg::coord_type       rsp_point_y,
   output hct_pkg::seg_type         rsp_point_number,
   output logic                     rsp_last_point,
   input  logic                     csr_write_enable,
   input  hct_pkg::seg_type         csr_write_data
);

   localparam int SegTop   = (1 << hct_pkg::SEG_W) - 1;
   localparam int MaxClamp = (MAX_SEGMENTS > SegTop) ? SegTop : MAX_SEGMENTS;
   localparam hct_pkg::seg_type MaxN = hct_pkg::seg_type'(MaxClamp);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_N2       = 4'd1;
   localparam logic [3:0] S_N3       = 4'd2;
   localparam logic [3:0] S_NCAP     = 4'd3;
   localparam logic [3:0] S_I2       = 4'd4;
   localparam logic [3:0] S_I3       = 4'd5;
   localparam logic [3:0] S_I2N      = 4'd6;
   localparam logic [3:0] S_IN2      = 4'd7;
   localparam logic [3:0] S_COEF     = 4'd8;
   localparam logic [3:0] S_MAC      = 4'd9;
   localparam logic [3:0] S_ACC_WAIT = 4'd10;
   localparam logic [3:0] S_DSTART   = 4'd11;
   localparam logic [3:0] S_DIV      = 4'd12;
   localparam logic [3:0] S_OUT      = 4'd13;

   localparam logic [1:0] TERM_P0 = 2'd0;
   localparam logic [1:0] TERM_P1 = 2'd1;
   localparam logic [1:0] TERM_T0 = 2'd2;
   localparam logic [1:0] TERM_T1 = 2'd3;

   logic [3:0]               state_ff;
   logic [3:0]               state_in;
   hct_pkg::seg_type         i_ff;
   hct_pkg::seg_type         i_in;
   logic [1:0]               term_ff;
   logic [1:0]               term_in;
   logic                     axis_ff;
   logic                     axis_in;
   hct_pkg::seg_type         segments_ff;
   hct_pkg::seg_type         segments_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;

   hct_pkg::seg_type         n_ff;
   hct_pkg::seg_type         n_eff;
   hct_pkg::sq_type          n2_ff;
   hct_pkg::cube_type        n3_ff;
   hct_pkg::sq_type          i2_ff;
   hct_pkg::cube_type        i3_ff;
   hct_pkg::cube_type        i2n_ff;
   hct_pkg::coef_type        h00_ff;
   hct_pkg::coef_type        h01_ff;
   hct_pkg::coef_type        h10_ff;
   hct_pkg::coef_type        h11_ff;
   hct_pkg::coord_type       p0x_ff;
   hct_pkg::coord_type       p0y_ff;
   hct_pkg::coord_type       p1x_ff;
   hct_pkg::coord_type       p1y_ff;
   hct_pkg::tan_type         t0x_ff;
   hct_pkg::tan_type         t0y_ff;
   hct_pkg::tan_type         t1x_ff;
   hct_pkg::tan_type         t1y_ff;
   hct_pkg::coord_type       px_ff;
   hct_pkg::coord_type       out_x_ff;
   hct_pkg::coord_type       out_y_ff;
   hct_pkg::seg_type         out_num_ff;
   logic                     out_last_ff;

   hct_pkg::hsum_type        i3_w;
   hct_pkg::hsum_type        i2n_w;
   hct_pkg::hsum_type        in2_w;
   hct_pkg::hsum_type        n3_w;
   hct_pkg::hsum_type        h00_w;
   hct_pkg::hsum_type        h01_w;
   hct_pkg::hsum_type        h10_w;
   hct_pkg::hsum_type        h11_w;

   logic                     accept;
   logic                     out_load;
   logic                     div_start;
   hct_pkg::mac_ctrl_type    mac_ctrl;
   hct_pkg::tan_type         op_a;
   hct_pkg::coef_type        op_b;
   hct_pkg::prod_type        product;
   hct_pkg::acc_type         acc;
   hct_pkg::div_result_type  div_result;

   hct_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mac_ctrl),
      .op_a    (op_a),
      .op_b    (op_b),
      .product (product),
      .acc     (acc)
   );

   hct_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc),
      .divisor  (n3_ff),
      .result   (div_result)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_load  = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign div_start = (state_ff == S_DSTART);

   always_comb begin
      if (segments_ff == '0) begin
         n_eff = hct_pkg::seg_type'(1);
      end else if (segments_ff > MaxN) begin
         n_eff = MaxN;
      end else begin
         n_eff = segments_ff;
      end
      segments_in  = csr_write_enable ? csr_write_data : segments_ff;
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   always_comb begin
      i3_w  = hct_pkg::hsum_type'(i3_ff);
      i2n_w = hct_pkg::hsum_type'(i2n_ff);
      in2_w = hct_pkg::hsum_type'(product[hct_pkg::CUBE_W-1:0]);
      n3_w  = hct_pkg::hsum_type'(n3_ff);
      h00_w = (i3_w <<< 1) - (i2n_w <<< 1) - i2n_w + n3_w;
      h01_w = (i2n_w <<< 1) + i2n_w - (i3_w <<< 1);
      h10_w = i3_w - (i2n_w <<< 1) + in2_w;
      h11_w = i3_w - i2n_w;
   end

   always_comb begin
      mac_ctrl.issue = 1'b0;
      mac_ctrl.first = 1'b1;
      op_a           = '0;
      op_b           = '0;
      case (state_ff)
         S_N2: begin
            mac_ctrl.issue = 1'b1;
            op_a           = hct_pkg::tan_type'(n_ff);
            op_b           = hct_pkg::coef_type'(n_ff);
         end
         S_N3: begin
            mac_ctrl.issue = 1'b1;
            op_a           = hct_pkg::tan_type'(product[hct_pkg::SQ_W-1:0]);
            op_b           = hct_pkg::coef_type'(n_ff);
         end
         S_NCAP, S_I2: begin
            mac_ctrl.issue = 1'b1;
            op_a           = hct_pkg::tan_type'(i_ff);
            op_b           = hct_pkg::coef_type'(i_ff);
         end
         S_I3: begin
            mac_ctrl.issue = 1'b1;
            op_a           = hct_pkg::tan_type'(product[hct_pkg::SQ_W-1:0]);
            op_b           = hct_pkg::coef_type'(i_ff);
         end
         S_I2N: begin
            mac_ctrl.issue = 1'b1;
            op_a           = hct_pkg::tan_type'(i2_ff);
            op_b           = hct_pkg::coef_type'(n_ff);
         end
         S_IN2: begin
            mac_ctrl.issue = 1'b1;
            op_a           = hct_pkg::tan_type'(i_ff);
            op_b           = hct_pkg::coef_type'(n2_ff);
         end
         S_MAC: begin
            mac_ctrl.issue = 1'b1;
            mac_ctrl.first = (term_ff == TERM_P0);
            case (term_ff)
               TERM_P0: begin
                  op_a = axis_ff ? hct_pkg::tan_type'(p0y_ff) : hct_pkg::tan_type'(p0x_ff);
                  op_b = h00_ff;
               end
               TERM_P1: begin
                  op_a = axis_ff ? hct_pkg::tan_type'(p1y_ff) : hct_pkg::tan_type'(p1x_ff);
                  op_b = h01_ff;
               end
               TERM_T0: begin
                  op_a = axis_ff ? t0y_ff : t0x_ff;
                  op_b = h10_ff;
               end
               TERM_T1: begin
                  op_a = axis_ff ? t1y_ff : t1x_ff;
                  op_b = h11_ff;
               end
               default: begin
                  op_a = '0;
                  op_b = '0;
               end
            endcase
         end
         default: begin
            mac_ctrl.issue = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      term_in  = term_ff;
      axis_in  = axis_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_N2;
               i_in     = '0;
            end
         end
         S_N2:   state_in = S_N3;
         S_N3:   state_in = S_NCAP;
         S_NCAP: state_in = S_I3;
         S_I2:   state_in = S_I3;
         S_I3:   state_in = S_I2N;
         S_I2N:  state_in = S_IN2;
         S_IN2:  state_in = S_COEF;
         S_COEF: begin
            state_in = S_MAC;
            term_in  = TERM_P0;
            axis_in  = 1'b0;
         end
         S_MAC: begin
            if (term_ff == TERM_T1) begin
               state_in = S_ACC_WAIT;
            end else begin
               term_in = term_ff + 2'd1;
            end
         end
         S_ACC_WAIT: state_in = S_DSTART;
         S_DSTART:   state_in = S_DIV;
         S_DIV: begin
            if (div_result.done) begin
               if (!axis_ff) begin
                  state_in = S_MAC;
                  axis_in  = 1'b1;
                  term_in  = TERM_P0;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (out_load) begin
               if (i_ff == n_ff) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_I2;
                  i_in     = i_ff + hct_pkg::seg_type'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         i_ff         <= '0;
         term_ff      <= TERM_P0;
         axis_ff      <= 1'b0;
         segments_ff  <= hct_pkg::SEG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         term_ff      <= term_in;
         axis_ff      <= axis_in;
         segments_ff  <= segments_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         n_ff   <= n_eff;
         p0x_ff <= req_start_x;
         p0y_ff <= req_start_y;
         p1x_ff <= req_end_x;
         p1y_ff <= req_end_y;
         t0x_ff <= hct_pkg::tan_type'(req_start_handle_x) - hct_pkg::tan_type'(req_start_x);
         t0y_ff <= hct_pkg::tan_type'(req_start_handle_y) - hct_pkg::tan_type'(req_start_y);
         t1x_ff <= hct_pkg::tan_type'(req_end_handle_x) - hct_pkg::tan_type'(req_end_x);
         t1y_ff <= hct_pkg::tan_type'(req_end_handle_y) - hct_pkg::tan_type'(req_end_y);
      end
      case (state_ff)
         S_N3:   n2_ff  <= product[hct_pkg::SQ_W-1:0];
         S_NCAP: n3_ff  <= product[hct_pkg::CUBE_W-1:0];
         S_I3:   i2_ff  <= product[hct_pkg::SQ_W-1:0];
         S_I2N:  i3_ff  <= product[hct_pkg::CUBE_W-1:0];
         S_IN2:  i2n_ff <= product[hct_pkg::CUBE_W-1:0];
         S_COEF: begin
            h00_ff <= h00_w[hct_pkg::COEF_W-1:0];
            h01_ff <= h01_w[hct_pkg::COEF_W-1:0];
            h10_ff <= h10_w[hct_pkg::COEF_W-1:0];
            h11_ff <= h11_w[hct_pkg::COEF_W-1:0];
         end
         S_DIV: begin
            if (div_result.done && !axis_ff) begin
               px_ff <= div_result.value;
            end
         end
         default: begin
         end
      endcase
      if (out_load) begin
         out_x_ff    <= px_ff;
         out_y_ff    <= div_result.value;
         out_num_ff  <= i_ff;
         out_last_ff <= (i_ff == n_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_point_x      = out_x_ff;
   assign rsp_point_y      = out_y_ff;
   assign rsp_point_number = out_num_ff;
   assign rsp_last_point   = out_last_ff;

`ifndef ASSERT_OFF
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_result.done |-> state_ff == S_DIV)
      else $error("divider result outside divide state");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (i_ff <= n_ff))
      else $error("point index beyond segment count");

   a_item_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_N2) && (i_ff == '0))
      else $error("item not started from index zero");
`endif

endmodule
